// ===== src/dir_pkg.sv =====
// shared types and constants for the debounced input reporter
package dir_pkg;

  localparam int TIMER_W_DEF = 32;
  localparam int GAP_W       = 8;
  localparam int LEN_W       = 4;
  localparam int PERIOD_W    = 32;
  localparam int OFFP_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [GAP_W-1:0]    GAP_RST    = 8'd3;
  localparam logic [LEN_W-1:0]    LEN_RST    = 4'd10;
  localparam logic [LEN_W-1:0]    THR_RST    = 4'd4;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 32'd100;
  localparam logic [OFFP_W-1:0]   OFFP_RST   = 16'd10;

  localparam logic [LEN_W-1:0] MATCH_MAX = 4'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_GAP      = 3'd0,
    REG_WINDOW_LEN      = 3'd1,
    REG_MATCH_THRESHOLD = 3'd2,
    REG_INVERT          = 3'd3,
    REG_REPORT_MODE     = 3'd4,
    REG_REPORT_PERIOD   = 3'd5,
    REG_OFFLINE_PERIOD  = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    DEST_HOST     = 1'b0,
    DEST_NEIGHBOR = 1'b1
  } dest_t;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_READ = 1'b1
  } in_mode_t;

  // request from the timing logic to the window logic
  typedef struct packed {
    logic en;
    logic pin;
  } dir_sample_t;

  // window settings
  typedef struct packed {
    logic [LEN_W-1:0] window_len;
    logic [LEN_W-1:0] match_threshold;
    logic             invert;
  } dir_win_cfg_t;

endpackage

// ===== src/dir_debounce.sv =====
// majority window: reference capture, match counting and debounced value
module dir_debounce (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dir_pkg::dir_sample_t  sample,
  input  dir_pkg::dir_win_cfg_t win_cfg,
  output logic                  logic_value,
  output logic                  logic_value_nxt
);
  import dir_pkg::*;

  logic [LEN_W-1:0] window_count_r, window_count_nxt;
  logic [LEN_W-1:0] match_count_r, match_count_nxt;
  logic             reference_r, reference_nxt;
  logic             logic_value_r;

  logic [LEN_W:0]   len;
  logic [LEN_W:0]   count_inc;
  logic [LEN_W-1:0] match_inc;
  logic             ref_now;

  always_comb begin
    // a zero length means a full sixteen-sample window
    len       = (win_cfg.window_len == '0) ? (LEN_W+1)'(1 << LEN_W)
                                           : {1'b0, win_cfg.window_len};
    ref_now   = (window_count_r == '0) ? sample.pin : reference_r;
    match_inc = match_count_r;
    if (sample.pin == ref_now && match_count_r < MATCH_MAX) begin
      match_inc = match_count_r + LEN_W'(1);
    end
    count_inc = {1'b0, window_count_r} + (LEN_W+1)'(1);

    window_count_nxt = window_count_r;
    match_count_nxt  = match_count_r;
    reference_nxt    = reference_r;
    logic_value_nxt  = logic_value_r;
    if (sample.en) begin
      reference_nxt = ref_now;
      if (count_inc >= len) begin
        window_count_nxt = '0;
        match_count_nxt  = '0;
        if (match_inc > win_cfg.match_threshold) begin
          logic_value_nxt = ref_now ^ win_cfg.invert;
        end
      end else begin
        window_count_nxt = count_inc[LEN_W-1:0];
        match_count_nxt  = match_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_count_r <= '0;
      match_count_r  <= '0;
      reference_r    <= 1'b0;
      logic_value_r  <= 1'b0;
    end else begin
      window_count_r <= window_count_nxt;
      match_count_r  <= match_count_nxt;
      reference_r    <= reference_nxt;
      logic_value_r  <= logic_value_nxt;
    end
  end

  assign logic_value = logic_value_r;

endmodule

// ===== src/debounced_input_reporter.sv =====
// top level of the debounced input reporter
// Input channel (in_valid/in_ready): one word per tick or host read request,
// fields in_mode, in_pin_level, in_online. Config channel (cfg_valid/cfg_ready)
// writes register cfg_index with cfg_data; it is always ready, and the user must
// write it only while the block is idle, which the block itself does not enforce.
// Result channel (out_valid/out_ready) carries out_destination and out_value,
// at most one result word per input word. An accepted word sits in an input
// register, is processed in a single pass through the timer compares and window
// logic, and any result lands in the output register that drives out_valid.
// Throughput is one word per cycle while the receiver takes results; the
// input register advances whenever the output register is empty or being
// read, so a stalled receiver holds one result and one pending input word and
// then backpressures through in_ready.
// Synchronous reset clears the timers, window state, debounced value, the
// pipeline valid flags and loads the default register values.
module debounced_input_reporter #(
  parameter int TIMER_WIDTH = dir_pkg::TIMER_W_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic                           in_pin_level,
  input  logic                           in_online,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dir_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_destination,
  output logic                           out_value
);
  import dir_pkg::*;

  // configuration registers
  logic [GAP_W-1:0]    sample_gap_r;
  dir_win_cfg_t        win_cfg_r;
  logic                report_mode_r;
  logic [PERIOD_W-1:0] report_period_r;
  logic [OFFP_W-1:0]   offline_period_r;

  // input stage
  logic in_valid_r, mode_r, pin_r, online_r;

  // timers
  logic [TIMER_WIDTH-1:0] sample_elapsed_r, sample_elapsed_nxt;
  logic [TIMER_WIDTH-1:0] online_elapsed_r, online_elapsed_nxt;
  logic [TIMER_WIDTH-1:0] offline_elapsed_r, offline_elapsed_nxt;
  logic [TIMER_WIDTH-1:0] sample_inc, online_inc, offline_inc;
  logic                   previous_value_r, previous_value_nxt;

  // output stage
  logic out_valid_r, out_dest_r, out_value_r;

  logic        advance, tick, emit, emit_dest, take_sample;
  logic        logic_value, logic_value_nxt;
  dir_sample_t sample;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_gap_r              <= GAP_RST;
      win_cfg_r.window_len      <= LEN_RST;
      win_cfg_r.match_threshold <= THR_RST;
      win_cfg_r.invert          <= 1'b0;
      report_mode_r             <= 1'b0;
      report_period_r           <= PERIOD_RST;
      offline_period_r          <= OFFP_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_SAMPLE_GAP:      sample_gap_r              <= cfg_data[GAP_W-1:0];
        REG_WINDOW_LEN:      win_cfg_r.window_len      <= cfg_data[LEN_W-1:0];
        REG_MATCH_THRESHOLD: win_cfg_r.match_threshold <= cfg_data[LEN_W-1:0];
        REG_INVERT:          win_cfg_r.invert          <= cfg_data[0];
        REG_REPORT_MODE:     report_mode_r             <= cfg_data[0];
        REG_REPORT_PERIOD:   report_period_r           <= cfg_data[PERIOD_W-1:0];
        REG_OFFLINE_PERIOD:  offline_period_r          <= cfg_data[OFFP_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign tick     = (in_mode_t'(mode_r) == MODE_TICK);

  always_comb begin
    sample_inc  = sample_elapsed_r + TIMER_WIDTH'(1);
    online_inc  = online_elapsed_r + TIMER_WIDTH'(1);
    offline_inc = offline_elapsed_r + TIMER_WIDTH'(1);
    take_sample = sample_inc > TIMER_WIDTH'(sample_gap_r);
  end

  assign sample.en  = advance && tick && take_sample;
  assign sample.pin = pin_r;

  dir_debounce u_debounce (
    .clk             (clk),
    .rst_n           (rst_n),
    .sample          (sample),
    .win_cfg         (win_cfg_r),
    .logic_value     (logic_value),
    .logic_value_nxt (logic_value_nxt)
  );

  always_comb begin
    sample_elapsed_nxt  = sample_elapsed_r;
    online_elapsed_nxt  = online_elapsed_r;
    offline_elapsed_nxt = offline_elapsed_r;
    previous_value_nxt  = previous_value_r;
    emit                = 1'b0;
    emit_dest           = DEST_HOST;
    if (advance) begin
      if (!tick) begin
        emit = 1'b1;
      end else begin
        sample_elapsed_nxt  = take_sample ? '0 : sample_inc;
        online_elapsed_nxt  = online_inc;
        offline_elapsed_nxt = offline_inc;
        if (online_r) begin
          if (!report_mode_r) begin
            if (PERIOD_W'(online_inc) > report_period_r) begin
              online_elapsed_nxt = '0;
              emit               = 1'b1;
            end
          end else if (logic_value_nxt != previous_value_r) begin
            previous_value_nxt = logic_value_nxt;
            emit               = 1'b1;
          end
        end else if (PERIOD_W'(offline_inc) > PERIOD_W'(offline_period_r)) begin
          offline_elapsed_nxt = '0;
          emit                = 1'b1;
          emit_dest           = DEST_NEIGHBOR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      sample_elapsed_r  <= '0;
      online_elapsed_r  <= '0;
      offline_elapsed_r <= '0;
      previous_value_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      sample_elapsed_r  <= sample_elapsed_nxt;
      online_elapsed_r  <= online_elapsed_nxt;
      offline_elapsed_r <= offline_elapsed_nxt;
      previous_value_r  <= previous_value_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r   <= in_mode;
      pin_r    <= in_pin_level;
      online_r <= in_online;
    end
    if (advance && emit) begin
      out_dest_r  <= emit_dest;
      out_value_r <= logic_value_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_destination = out_dest_r;
  assign out_value       = out_value_r;

  // a read request always yields a host word carrying the held value
  a_read_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !tick) |=> (out_valid && out_destination == DEST_HOST
                            && out_value == $past(logic_value)))
    else $error("read request did not produce a host word");

  // a stalled result word is never dropped
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("result word lost while receiver stalled");

  // taking a sample restarts the sample timer
  a_sample_restart: assert property (@(posedge clk) disable iff (!rst_n)
    sample.en |=> (sample_elapsed_r == '0))
    else $error("sample timer not restarted");

  // neighbor words only come from offline ticks
  a_neighbor_offline: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit && emit_dest == DEST_NEIGHBOR) |-> (tick && !online_r))
    else $error("neighbor word outside offline tick");

  // time stands still on a read request
  a_read_no_time: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !tick) |=> $stable(online_elapsed_r) && $stable(offline_elapsed_r))
    else $error("read request advanced a timer");

endmodule

// ===== tb/tb.sv =====
// testbench for the debounced input reporter: directed and random ticks checked against a local debouncer
`timescale 1ns / 1ps

module tb;
  import dir_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [GAP_W-1:0]    sample_gap;
    logic [LEN_W-1:0]    window_len;
    logic [LEN_W-1:0]    match_threshold;
    logic                invert;
    logic                report_mode;
    logic [PERIOD_W-1:0] report_period;
    logic [OFFP_W-1:0]   offline_period;
  } settings_t;

  typedef struct {
    dest_t dest;
    logic  value;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = MODE_TICK;
  logic in_pin_level = 1'b0;
  logic in_online = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic out_destination;
  logic out_value;

  // local copy of the debouncer
  settings_t cur_cfg = {GAP_RST, LEN_RST, THR_RST, 1'b0, 1'b0, PERIOD_RST, OFFP_RST};
  logic [31:0] sample_timer = '0;
  logic [31:0] host_timer = '0;
  logic [31:0] neighbor_timer = '0;
  logic [LEN_W-1:0] win_count = '0;
  logic [LEN_W-1:0] match_count = '0;
  logic ref_level = 1'b0;
  logic deb_value = 1'b0;
  logic last_host_value = 1'b0;

  report_t pending_reports[$];
  int fail_count = 0;
  int idle_pct = 0;

  debounced_input_reporter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_pin_level    (in_pin_level),
    .in_online       (in_online),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_destination (out_destination),
    .out_value       (out_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void push_report(dest_t d, logic v);
    report_t r;
    r.dest = d;
    r.value = v;
    pending_reports.push_back(r);
  endfunction

  function automatic void advance_debouncer(in_mode_t m, logic pin, logic onl);
    logic [4:0] span;
    logic [4:0] next_count;
    if (m == MODE_READ) begin
      push_report(DEST_HOST, deb_value);
      return;
    end
    sample_timer = sample_timer + 32'd1;
    host_timer = host_timer + 32'd1;
    neighbor_timer = neighbor_timer + 32'd1;
    if (sample_timer > cur_cfg.sample_gap) begin
      sample_timer = '0;
      span = (cur_cfg.window_len == 0) ? 5'd16 : {1'b0, cur_cfg.window_len};
      if (win_count == 0) ref_level = pin;
      if (pin == ref_level && match_count < MATCH_MAX) match_count = match_count + LEN_W'(1);
      next_count = {1'b0, win_count} + 5'd1;
      // window also closes when its length was cut below the current count
      if (next_count >= span) begin
        win_count = '0;
        if (match_count > cur_cfg.match_threshold) deb_value = ref_level ^ cur_cfg.invert;
        match_count = '0;
      end else begin
        win_count = next_count[LEN_W-1:0];
      end
    end
    if (onl) begin
      if (!cur_cfg.report_mode) begin
        if (host_timer > cur_cfg.report_period) begin
          host_timer = '0;
          push_report(DEST_HOST, deb_value);
        end
      end else if (deb_value != last_host_value) begin
        last_host_value = deb_value;
        push_report(DEST_HOST, deb_value);
      end
    end else if (neighbor_timer > cur_cfg.offline_period) begin
      neighbor_timer = '0;
      push_report(DEST_NEIGHBOR, deb_value);
    end
  endfunction

  function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_SAMPLE_GAP:      cur_cfg.sample_gap = d[GAP_W-1:0];
      REG_WINDOW_LEN:      cur_cfg.window_len = d[LEN_W-1:0];
      REG_MATCH_THRESHOLD: cur_cfg.match_threshold = d[LEN_W-1:0];
      REG_INVERT:          cur_cfg.invert = d[0];
      REG_REPORT_MODE:     cur_cfg.report_mode = d[0];
      REG_REPORT_PERIOD:   cur_cfg.report_period = d[PERIOD_W-1:0];
      REG_OFFLINE_PERIOD:  cur_cfg.offline_period = d[OFFP_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic settings_t pack_settings(int gap, int len, int thr, bit inv, bit rmode,
                                              logic [31:0] rper, logic [15:0] oper);
    settings_t s;
    s.sample_gap = gap[GAP_W-1:0];
    s.window_len = len[LEN_W-1:0];
    s.match_threshold = thr[LEN_W-1:0];
    s.invert = inv;
    s.report_mode = rmode;
    s.report_period = rper;
    s.offline_period = oper;
    return s;
  endfunction

  function automatic settings_t random_settings();
    settings_t s;
    s.sample_gap = ($urandom_range(0, 9) == 0) ? GAP_W'($urandom) : GAP_W'($urandom_range(0, 3));
    s.window_len = ($urandom_range(0, 2) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(1, 4));
    s.match_threshold = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom)
                                                   : LEN_W'($urandom_range(0, 2));
    s.invert = 1'($urandom_range(0, 1));
    s.report_mode = 1'($urandom_range(0, 1));
    s.report_period = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 30);
    s.offline_period = ($urandom_range(0, 7) == 0) ? 16'hFFFF : OFFP_W'($urandom_range(0, 30));
    return s;
  endfunction

  // all registers back to back, plus a stray write to an unused index
  task automatic apply_settings(settings_t s);
    logic [CFG_IDX_W-1:0] idx [8];
    logic [CFG_DATA_W-1:0] val [8];
    idx[0] = REG_UNUSED;          val[0] = $urandom;
    idx[1] = REG_SAMPLE_GAP;      val[1] = CFG_DATA_W'({$urandom, s.sample_gap});
    idx[2] = REG_WINDOW_LEN;      val[2] = CFG_DATA_W'({$urandom, s.window_len});
    idx[3] = REG_MATCH_THRESHOLD; val[3] = CFG_DATA_W'({$urandom, s.match_threshold});
    idx[4] = REG_INVERT;          val[4] = CFG_DATA_W'({$urandom, s.invert});
    idx[5] = REG_REPORT_MODE;     val[5] = CFG_DATA_W'({$urandom, s.report_mode});
    idx[6] = REG_REPORT_PERIOD;   val[6] = s.report_period;
    idx[7] = REG_OFFLINE_PERIOD;  val[7] = CFG_DATA_W'({$urandom, s.offline_period});
    for (int k = 0; k < 8; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      do @(posedge clk); while (!cfg_ready);
      store_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  // valid is left high after acceptance; whoever waits next lowers it
  task automatic send_word(in_mode_t m, logic pin, logic onl);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_pin_level <= pin;
    in_online <= onl;
    do @(posedge clk); while (!in_ready);
    advance_debouncer(m, pin, onl);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic settle_block();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // pin held in runs with the odd bounce, online status in runs, some host reads
  task automatic run_traffic(int count);
    logic level;
    logic onl;
    logic pin;
    int run_left;
    int onl_left;
    level = 1'($urandom_range(0, 1));
    onl = 1'($urandom_range(0, 1));
    run_left = $urandom_range(1, 40);
    onl_left = $urandom_range(5, 80);
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        level = ~level;
        run_left = $urandom_range(1, 40);
      end
      run_left--;
      if (onl_left == 0) begin
        onl = ~onl;
        onl_left = $urandom_range(5, 80);
      end
      onl_left--;
      pin = ($urandom_range(0, 11) == 0) ? ~level : level;
      if ($urandom_range(0, 9) == 0)
        send_word(MODE_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else
        send_word(MODE_TICK, pin, onl);
      if ($urandom_range(0, 149) == 0) wait_for_results();
    end
  endtask

  task automatic test_reset_values();
    send_word(MODE_READ, 1'b1, 1'b1);
    // offline report once the default offline period is exceeded
    repeat (11) send_word(MODE_TICK, 1'b1, 1'b0);
  endtask

  task automatic test_fast_response();
    settle_block();
    apply_settings(pack_settings(0, 1, 0, 1'b0, 1'b1, 32'd0, 16'd0));
    send_word(MODE_READ, 1'b0, 1'b0);
    send_word(MODE_TICK, 1'b1, 1'b1);
    send_word(MODE_TICK, 1'b1, 1'b1);
    send_word(MODE_TICK, 1'b0, 1'b0);
    send_word(MODE_READ, 1'b1, 1'b1);
  endtask

  task automatic test_window_shrink();
    settle_block();
    apply_settings(pack_settings(0, 15, 0, 1'b1, 1'b0, 32'd0, 16'd0));
    repeat (3) send_word(MODE_TICK, 1'b0, 1'b1);
    settle_block();
    apply_settings(pack_settings(0, 2, 0, 1'b1, 1'b0, 32'd0, 16'd0));
    send_word(MODE_TICK, 1'b0, 1'b1);
  endtask

  task automatic test_extreme_settings();
    settle_block();
    apply_settings(pack_settings(255, 0, 15, 1'b1, 1'b0, 32'hFFFF_FFFF, 16'hFFFF));
    send_word(MODE_TICK, 1'b1, 1'b1);
    send_word(MODE_TICK, 1'b0, 1'b0);
    send_word(MODE_READ, 1'b0, 1'b1);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 6; p++) begin
      settle_block();
      apply_settings(random_settings());
      idle_pct = 10 * $urandom_range(0, 3);
      run_traffic(55);
      wait_for_results();
      run_traffic(55);
    end
  endtask

  task automatic test_steady_stream();
    settle_block();
    apply_settings(random_settings());
    idle_pct = 0;
    run_traffic(90);
  endtask

  always begin
    @(posedge clk);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("unexpected word: destination %0b value %0b", out_destination, out_value);
      end else begin
        want = pending_reports.pop_front();
        if (out_destination !== want.dest || out_value !== want.value) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("mismatch: destination exp %0b got %0b, value exp %0b got %0b",
                     want.dest, out_destination, want.value, out_value);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_fast_response();
    test_window_shrink();
    test_extreme_settings();
    idle_pct = 20;
    test_random_phases();
    test_steady_stream();
    settle_block();
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
